// ===== hdl/stl_pkg.sv =====
package stl_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    KIND_WORD       = 4'd0,
    KIND_QUOTED     = 4'd1,
    KIND_PIPE       = 4'd2,
    KIND_BACKGROUND = 4'd3,
    KIND_FILEOUT    = 4'd4,
    KIND_TCPOUT     = 4'd5,
    KIND_FILEIN     = 4'd6,
    KIND_TCPIN      = 4'd7,
    KIND_SEMICOLON  = 4'd8,
    KIND_NEWLINE    = 4'd9,
    KIND_EOF        = 4'd10,
    KIND_ERROR      = 4'd11
  } token_kind_e;

  // Lexer mode, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE      = 8'b0000_0001,
    MODE_COMMENT   = 8'b0000_0010,
    MODE_WORD      = 8'b0000_0100,
    MODE_WORD_ESC  = 8'b0000_1000,
    MODE_QUOTE     = 8'b0001_0000,
    MODE_QUOTE_ESC = 8'b0010_0000,
    MODE_GT        = 8'b0100_0000,
    MODE_LT        = 8'b1000_0000
  } lex_mode_e;

  localparam int unsigned StartW = 12;
  localparam int unsigned LenW   = 13;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef struct packed {
    token_kind_e        kind;
    logic [StartW-1:0]  start;
    logic [LenW-1:0]    length;
    logic               last;
  } token_t;

  // Results of one lexer step, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } token_push_t;

endpackage

// ===== hdl/stl_lexer.sv =====
module stl_lexer #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  logic [7:0]           char_code_i,
  output stl_pkg::token_push_t push_o
);
  import stl_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_LINE + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_LINE);
  localparam logic [PosW:0] StartMax = (PosW + 1)'(MAX_LINE - 1);

  lex_mode_e       mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] beg_q, beg_d;

  function automatic logic [PosW-1:0] bump(input logic [PosW-1:0] p);
    return (p < PosMax) ? p + 1'b1 : p;
  endfunction

  function automatic logic [PosW-1:0] span(input logic [PosW-1:0] p,
                                           input logic [PosW-1:0] b);
    return (p >= b) ? p - b : '0;
  endfunction

  function automatic logic is_plain(input logic [7:0] c);
    logic r;
    case (c)
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SEMI, CH_PIPE,
      CH_GT, CH_LT, CH_QUOTE, CH_AMP, CH_NUL, CH_HASH: r = 1'b0;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // Clamp start to the last line position, then fit the field
  function automatic token_t make_tok(input token_kind_e k,
                                      input logic [PosW:0] s,
                                      input logic [PosW-1:0] l);
    token_t   t;
    logic [PosW:0] sc;
    logic [31:0] sw;
    logic [31:0] lw;
    sc = (s > StartMax) ? StartMax : s;
    sw = 32'(sc);
    lw = 32'(l);
    t.kind   = k;
    t.start  = sw[StartW-1:0];
    t.length = lw[LenW-1:0];
    t.last   = 1'b0;
    return t;
  endfunction

  token_t          pre_tok, idle_tok;
  logic            pre_v, idle_v, do_idle;
  logic [PosW-1:0] qspan;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    beg_d    = beg_q;
    pre_v    = 1'b0;
    idle_v   = 1'b0;
    do_idle  = 1'b0;
    pre_tok  = make_tok(KIND_EOF, '0, '0);
    idle_tok = make_tok(KIND_EOF, '0, '0);
    qspan    = span(bump(pos_q), beg_q);

    case (mode_q)
      MODE_COMMENT: begin
        if (char_code_i == CH_LF || char_code_i == CH_NUL) do_idle = 1'b1;
        else pos_d = bump(pos_q);
      end
      MODE_WORD: begin
        if (char_code_i == CH_BSLASH) begin
          mode_d = MODE_WORD_ESC;
        end else if (is_plain(char_code_i)) begin
          pos_d = bump(pos_q);
        end else begin
          pre_v   = 1'b1;
          pre_tok = make_tok(KIND_WORD, {1'b0, beg_q}, span(pos_q, beg_q));
          do_idle = 1'b1;
        end
      end
      MODE_WORD_ESC, MODE_QUOTE_ESC: begin
        if (char_code_i == CH_NUL) begin
          pre_v   = 1'b1;
          pre_tok = make_tok(KIND_ERROR, {1'b0, beg_q}, span(pos_q, beg_q));
          do_idle = 1'b1;
        end else begin
          pos_d  = bump(pos_q);
          mode_d = (mode_q == MODE_WORD_ESC) ? MODE_WORD : MODE_QUOTE;
        end
      end
      MODE_QUOTE: begin
        if (char_code_i == CH_NUL) begin
          pre_v   = 1'b1;
          pre_tok = make_tok(KIND_ERROR, {1'b0, beg_q}, span(pos_q, beg_q));
          do_idle = 1'b1;
        end else if (char_code_i == CH_BSLASH) begin
          mode_d = MODE_QUOTE_ESC;
        end else if (char_code_i == CH_QUOTE) begin
          pos_d   = bump(pos_q);
          pre_v   = 1'b1;
          pre_tok = make_tok(KIND_QUOTED, {1'b0, beg_q} + 1'b1,
                             (qspan >= PosW'(2)) ? qspan - PosW'(2) : '0);
          mode_d  = MODE_IDLE;
        end else begin
          pos_d = bump(pos_q);
        end
      end
      MODE_GT, MODE_LT: begin
        pre_v = 1'b1;
        if (char_code_i == CH_AT) begin
          pos_d   = bump(pos_q);
          pre_tok = make_tok((mode_q == MODE_GT) ? KIND_TCPOUT : KIND_TCPIN,
                             {1'b0, beg_q}, PosW'(2));
          mode_d  = MODE_IDLE;
        end else begin
          pre_tok = make_tok((mode_q == MODE_GT) ? KIND_FILEOUT : KIND_FILEIN,
                             {1'b0, beg_q}, PosW'(1));
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Between tokens: the position is untouched by every path that lands here
    if (do_idle) begin
      mode_d = MODE_IDLE;
      case (char_code_i)
        CH_SPACE, CH_TAB, CH_CR: pos_d = bump(pos_q);
        CH_HASH: begin
          mode_d = MODE_COMMENT;
          pos_d  = bump(pos_q);
        end
        CH_NUL: begin
          idle_v   = 1'b1;
          idle_tok = make_tok(KIND_EOF, '0, '0);
          pos_d    = '0;
          beg_d    = '0;
        end
        CH_BSLASH: begin
          beg_d  = pos_q;
          mode_d = MODE_WORD_ESC;
        end
        CH_QUOTE: begin
          beg_d  = pos_q;
          pos_d  = bump(pos_q);
          mode_d = MODE_QUOTE;
        end
        CH_GT: begin
          beg_d  = pos_q;
          pos_d  = bump(pos_q);
          mode_d = MODE_GT;
        end
        CH_LT: begin
          beg_d  = pos_q;
          pos_d  = bump(pos_q);
          mode_d = MODE_LT;
        end
        CH_PIPE, CH_AMP, CH_SEMI, CH_LF, CH_VT, CH_FF: begin
          idle_v = 1'b1;
          pos_d  = bump(pos_q);
          case (char_code_i)
            CH_PIPE: idle_tok = make_tok(KIND_PIPE, {1'b0, pos_q}, PosW'(1));
            CH_AMP:  idle_tok = make_tok(KIND_BACKGROUND, {1'b0, pos_q}, PosW'(1));
            CH_SEMI: idle_tok = make_tok(KIND_SEMICOLON, {1'b0, pos_q}, PosW'(1));
            CH_LF:   idle_tok = make_tok(KIND_NEWLINE, {1'b0, pos_q}, PosW'(1));
            default: idle_tok = make_tok(KIND_ERROR, {1'b0, pos_q}, PosW'(1));
          endcase
        end
        default: begin
          beg_d  = pos_q;
          pos_d  = bump(pos_q);
          mode_d = MODE_WORD;
        end
      endcase
    end

    push_o.count  = 2'(pre_v) + 2'(idle_v);
    push_o.first  = pre_v ? pre_tok : idle_tok;
    push_o.second = idle_tok;
    push_o.first.last  = !(pre_v && idle_v);
    push_o.second.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      beg_q  <= '0;
    end else if (step_en_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      beg_q  <= beg_d;
    end
  end

endmodule

// ===== hdl/stl_out_queue.sv =====
module stl_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_en_i,
  input  stl_pkg::token_push_t push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output stl_pkg::token_t      token_o
);
  import stl_pkg::*;

  localparam int unsigned Depth = 4;

  token_t     slots_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n_push;
  logic       pop;

  assign n_push  = push_en_i ? push_i.count : 2'd0;
  assign pop     = (cnt_q != 3'd0) && ready_i;
  assign cnt_d   = cnt_q + 3'(n_push) - 3'(pop);
  // Room for two more items regardless of a pop this cycle
  assign room_o  = (cnt_q <= 3'd2);
  assign valid_o = (cnt_q != 3'd0);
  assign token_o = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) slots_q[wr_q] <= push_i.first;
    if (n_push == 2'd2) slots_q[wr_q + 2'd1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/shell_token_lexer.sv =====
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] char_code
// m_axis    out  m_axis_tvalid/tready       tdata[3:0] token_kind, [15:4] token_start,
//                                           [28:16] token_length; tlast last_of_run
//
// One byte per cycle while the result queue has room; a byte that yields two
// tokens (an open token closed by a delimiter that is a token itself, or end
// of line) writes both into the result queue at once, and they leave it in turn.
// The byte register feeds the combinational lexer, whose tokens are registered in the queue.
// Reset clears mode, positions and the queue; no clearing pass is needed.
// A stalled output backs up through the four-entry queue into the byte register.
module shell_token_lexer #(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [3:0] token_kind, [15:4] token_start,
                                        // [28:16] token_length, [31:29] zero
  output logic        m_axis_tlast_o
);
  import stl_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        step_en;
  logic        room;
  token_push_t push;
  token_t      tok;

  // Advance the lexer only when the queue can absorb both possible tokens
  assign step_en         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || step_en;

  // Input register: hold the byte until the lexer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_byte_q <= s_axis_tdata_i;
  end

  stl_lexer #(
    .MAX_LINE(MAX_LINE)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step_en),
    .char_code_i(in_byte_q),
    .push_o     (push)
  );

  stl_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(step_en),
    .push_i   (push),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .token_o  (tok)
  );

  // Pack the item, first field lowest
  assign m_axis_tdata_o = {3'b000, tok.length, tok.start, tok.kind};
  assign m_axis_tlast_o = tok.last;

endmodule
